>>> hdl/lcm_pkg.sv
// Package for the least common multiple unit: payload types, ALU codes and defaults.
`default_nettype none
package lcm_pkg;

    // Default word width of the arithmetic.
    localparam int WORD_BITS_DEF = 32;

    // Operation codes for the shared add/subtract unit.
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // One input item.
    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [31:0] multiple;
        logic        overflow;
    } t_out;

    // Control of the shared add/subtract unit.
    typedef struct packed {
        logic op;
    } t_alu_ctl;

endpackage
`default_nettype wire

>>> hdl/lcm_alu.sv
// Shared add/subtract unit used by the GCD, divide and multiply phases of the sequencer.
`default_nettype none
module lcm_alu #(
    parameter int WORD_BITS = lcm_pkg::WORD_BITS_DEF
) (
    input  wire lcm_pkg::t_alu_ctl    i_ctl,
    input  wire logic [WORD_BITS:0]   i_x,
    input  wire logic [WORD_BITS:0]   i_y,
    output logic      [WORD_BITS:0]   o_res,
    output logic                      o_borrow
);

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS:0]   y_eff;

    // Subtraction is addition of the complement with a carry in.
    always_comb begin
        y_eff = (i_ctl.op == lcm_pkg::ALU_SUB) ? ~i_y : i_y;
        sum   = {1'b0, i_x} + {1'b0, y_eff}
              + {{(WORD_BITS+1){1'b0}}, (i_ctl.op == lcm_pkg::ALU_SUB)};
        o_res    = sum[WORD_BITS:0];
        o_borrow = (i_ctl.op == lcm_pkg::ALU_SUB) && !sum[WORD_BITS+1];
    end

endmodule
`default_nettype wire

>>> hdl/lcm_unit.sv
// Least common multiple unit: binary GCD, restoring divide and shift-add multiply.
// Sequence: a zero operand goes straight to the result; otherwise common factors of two are
// stripped, the binary GCD runs, the first operand is divided by the GCD and the quotient
// is multiplied by the second operand.
// Throughput: one item at a time; a result the receiver has not taken holds the next one.
// Reset: synchronous, active low; clears the sequencer and the output valid flag.
`default_nettype none
module lcm_unit #(
    parameter int WORD_BITS = lcm_pkg::WORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire lcm_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output lcm_pkg::t_out    o_out_data
);

    localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(WORD_BITS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TWOS = 3'd1;
    localparam logic [2:0] S_GCD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_x, n_x;
    logic [WORD_BITS-1:0] r_y, n_y;
    logic [WORD_BITS-1:0] r_a, n_a;
    logic [WORD_BITS-1:0] r_b, n_b;
    logic [WORD_BITS:0]   r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_zero, n_zero;
    logic                 r_out_valid, n_out_valid;
    lcm_pkg::t_out        r_out, n_out;

    logic [WORD_BITS-1:0] a_in, b_in;
    logic                 in_fire;
    lcm_pkg::t_alu_ctl    alu_ctl;
    logic [WORD_BITS:0]   alu_x, alu_y, alu_res;
    logic                 alu_borrow;
    logic [WORD_BITS:0]   div_shift;
    logic [63:0]          prod_wide;

    // Operands reduced to the word width.
    assign a_in    = WORD_BITS'(i_in_data.operand_a);
    assign b_in    = WORD_BITS'(i_in_data.operand_b);
    assign in_fire = i_in_valid && o_in_ready;

    assign div_shift = {r_rem[WORD_BITS-1:0], r_a[WORD_BITS-1]};
    assign prod_wide = 64'(r_a);

    // Operand selection for the shared adder.
    always_comb begin
        alu_ctl.op = lcm_pkg::ALU_SUB;
        alu_x      = {1'b0, r_x};
        alu_y      = {1'b0, r_y};
        case (r_state)
            S_DIV: begin
                alu_x = div_shift;
                alu_y = {1'b0, r_y};
            end
            S_MUL: begin
                alu_ctl.op = lcm_pkg::ALU_ADD;
                alu_x      = r_rem;
                alu_y      = r_a[0] ? {1'b0, r_b} : '0;
            end
            default: begin
                alu_x = {1'b0, r_x};
                alu_y = {1'b0, r_y};
            end
        endcase
    end

    lcm_alu #(
        .WORD_BITS(WORD_BITS)
    ) u_alu (
        .i_ctl    (alu_ctl),
        .i_x      (alu_x),
        .i_y      (alu_y),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_a         = r_a;
        n_b         = r_b;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_zero      = r_zero;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_x    = a_in;
                    n_y    = b_in;
                    n_a    = a_in;
                    n_b    = b_in;
                    n_zero = (a_in == '0) || (b_in == '0);
                    n_state = ((a_in == '0) || (b_in == '0)) ? S_DONE : S_TWOS;
                end
            end
            S_TWOS: begin
                // Strip common factors of two; the dividend loses them too.
                if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_a = r_a >> 1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                // Binary GCD: halve even values, otherwise subtract or swap.
                if (r_y == '0) begin
                    n_y     = r_x;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else if (r_x == '0) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (!alu_borrow) begin
                    n_x = alu_res[WORD_BITS:1];
                end else begin
                    n_x = r_y;
                    n_y = r_x;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem = alu_borrow ? div_shift : alu_res;
                n_a   = {r_a[WORD_BITS-2:0], !alu_borrow};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Shift-add multiply; the high half collects in the remainder register.
                n_rem = {1'b0, alu_res[WORD_BITS:1]};
                n_a   = {alu_res[0], r_a[WORD_BITS-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    if (r_zero) begin
                        n_out.multiple = '0;
                        n_out.overflow = 1'b0;
                    end else if (r_rem != '0) begin
                        n_out.multiple = '0;
                        n_out.overflow = 1'b1;
                    end else begin
                        n_out.multiple = prod_wide[31:0];
                        n_out.overflow = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_zero      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_zero      <= n_zero;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An overflowing result is always reported with a zero multiple.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overflow) |-> (r_out.multiple == '0))
        else $error("overflow reported with a non-zero multiple");

    // The divisor is never zero during division.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_y != '0))
        else $error("division by zero in sequencer");

    // Once common twos are stripped, at least one GCD operand stays odd.
    a_gcd_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_x[0] || r_y[0]))
        else $error("both GCD operands even");

    // A zero operand skips straight to the result.
    a_zero_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && ((a_in == '0) || (b_in == '0))) |=> (r_state == S_DONE))
        else $error("zero operand did not skip the arithmetic");

endmodule
`default_nettype wire
